[rtl/sbdf_pkg.sv]
// Shared types and constants of the signed BCD display formatter.
// Used by the channel interfaces and by the top level; depends on nothing.
package sbdf_pkg;

	localparam int NUM_DIGITS = 10;
	localparam int MAG_W      = 32;
	localparam int BIT_CNT_W  = $clog2(MAG_W);
	localparam int IDX_W      = $clog2(NUM_DIGITS);

	localparam int VALUE_W = 32;
	localparam int SPOS_W  = 4;
	localparam int PPOS_W  = 4;
	localparam int POS_W   = 4;
	localparam int CHAR_W  = 6;

	// ASCII codes, truncated to the character field width.
	localparam logic [CHAR_W-1:0] CH_SPACE = 6'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 6'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 6'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 6'h30;

	// BCD correction added to a doubled digit that passes nine.
	localparam logic [4:0] BCD_ADJ   = 5'h06;
	localparam logic [3:0] BCD_LIMIT = 4'd5;

	typedef logic [3:0] digit_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		PH_SIGN  = 3'b001,
		PH_DIGIT = 3'b010,
		PH_POINT = 3'b100
	} phase_t;

endpackage

[rtl/sbdf_if.sv]
// Valid/ready channel interfaces of the signed BCD display formatter.
// Field widths come from sbdf_pkg.
interface sbdf_item_if;
	logic                                valid;
	logic                                ready;
	logic signed [sbdf_pkg::VALUE_W-1:0] value;
	logic        [sbdf_pkg::SPOS_W-1:0]  start_pos;
	logic        [sbdf_pkg::PPOS_W-1:0]  point_pos;

	modport source (output valid, value, start_pos, point_pos, input ready);
	modport sink (input valid, value, start_pos, point_pos, output ready);
endinterface

interface sbdf_result_if;
	logic                          valid;
	logic                          ready;
	logic [sbdf_pkg::POS_W-1:0]    position;
	logic [sbdf_pkg::CHAR_W-1:0]   character;
	logic                          last;

	modport source (output valid, position, character, last, input ready);
	modport sink (input valid, position, character, last, output ready);
endinterface

interface sbdf_cfg_if;
	logic valid;
	logic ready;
	logic hi_res;

	modport source (output valid, hi_res, input ready);
	modport sink (input valid, hi_res, output ready);
endinterface

[rtl/signed_bcd_display_formatter.sv]
// Signed BCD display formatter: converts one signed value into character
// beats for a 16-character message line. Depends on sbdf_pkg and sbdf_if.sv.

// One value is handled at a time. After the input beat is taken, the magnitude
// is shifted one bit per cycle into a row of ten BCD digit cells until all 32
// magnitude bits are in; then one character beat leaves per cycle (1 to 12
// beats) while the output side keeps up. The time a value occupies the block
// is set by the bit-serial conversion shift register plus the
// one-beat-per-cycle write sequencer. The next value is taken as soon as the
// last beat sits in the output register. The hi_res register is sampled when
// a value is taken and may be written at any time the block is idle; its port
// is always ready.
module signed_bcd_display_formatter (
	input  logic                  clk,
	input  logic                  arst_n,
	sbdf_cfg_if.sink              cfg,
	sbdf_item_if.sink             item,
	sbdf_result_if.source         result
);

	localparam logic [sbdf_pkg::IDX_W-1:0] LAST_IDX =
		sbdf_pkg::IDX_W'(sbdf_pkg::NUM_DIGITS - 1);
	localparam logic [sbdf_pkg::SPOS_W-1:0] SPOS_MAX =
		sbdf_pkg::SPOS_W'(sbdf_pkg::NUM_DIGITS);
	localparam logic [sbdf_pkg::BIT_CNT_W-1:0] LAST_BIT =
		sbdf_pkg::BIT_CNT_W'(sbdf_pkg::MAG_W - 1);

	sbdf_pkg::state_t state_q;
	sbdf_pkg::phase_t ph_q;
	logic hi_res_q;

	// Conversion datapath: magnitude shift register and the BCD digit row.
	// Digit 0 is the most significant.
	logic [sbdf_pkg::MAG_W-1:0]     mag_q;
	logic [sbdf_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	sbdf_pkg::digit_t               dig_q [sbdf_pkg::NUM_DIGITS];
	sbdf_pkg::digit_t               dig_next [sbdf_pkg::NUM_DIGITS];
	logic [sbdf_pkg::NUM_DIGITS:0]  carry;

	// Per-value formatting context.
	logic                           minus_q;
	logic [sbdf_pkg::IDX_W-1:0]     first_q;
	logic [sbdf_pkg::IDX_W-1:0]     idx_q;
	logic [sbdf_pkg::POS_W-1:0]     n_q;
	logic                           pt_en_q;
	logic [sbdf_pkg::PPOS_W-1:0]    pt_q;
	logic                           blank_q;

	// Output register.
	logic                           o_valid_q;
	logic [sbdf_pkg::POS_W-1:0]     o_pos_q;
	logic [sbdf_pkg::CHAR_W-1:0]    o_char_q;
	logic                           o_last_q;

	logic item_acc;
	logic [sbdf_pkg::SPOS_W-1:0] sp_lo;
	logic [sbdf_pkg::SPOS_W-1:0] sp_c;
	logic [sbdf_pkg::SPOS_W-1:0] first_in;
	logic [sbdf_pkg::MAG_W-1:0]  raw;

	sbdf_pkg::digit_t cur_d;
	logic is_pt;
	logic sig;
	logic ovf;
	logic need_sign;
	logic sign_wr;
	logic pt_wr;
	logic load;
	logic [sbdf_pkg::POS_W-1:0]  w_pos;
	logic [sbdf_pkg::CHAR_W-1:0] w_char;
	logic                        w_last;
	logic                        w_end;

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == sbdf_pkg::ST_IDLE);
	assign item_acc   = item.valid && item.ready;

	assign result.valid     = o_valid_q;
	assign result.position  = o_pos_q;
	assign result.character = o_char_q;
	assign result.last      = o_last_q;

	// Start position is clamped to [1,10], or to [2,10] in hi-res mode. The
	// first shown digit sits one place left of the start in hi-res mode.
	assign raw   = item.value;
	assign sp_lo = hi_res_q ? sbdf_pkg::SPOS_W'(2) : sbdf_pkg::SPOS_W'(1);
	always_comb begin
		if (item.start_pos < sp_lo) begin
			sp_c = sp_lo;
		end else if (item.start_pos > SPOS_MAX) begin
			sp_c = SPOS_MAX;
		end else begin
			sp_c = item.start_pos;
		end
		first_in = hi_res_q ? (sp_c - sbdf_pkg::SPOS_W'(2)) : (sp_c - sbdf_pkg::SPOS_W'(1));
	end

	// One shift-and-correct step. A digit of five or more doubles past nine,
	// so each cell's carry depends only on its own digit and there is no chain.
	always_comb begin
		logic [4:0] d5;
		carry[sbdf_pkg::NUM_DIGITS] = mag_q[sbdf_pkg::MAG_W-1];
		for (int k = 0; k < sbdf_pkg::NUM_DIGITS; k++) begin
			carry[k] = (dig_q[k] >= sbdf_pkg::BCD_LIMIT);
		end
		for (int k = 0; k < sbdf_pkg::NUM_DIGITS; k++) begin
			d5 = {dig_q[k], carry[k+1]};
			if (carry[k]) begin
				d5 = d5 + sbdf_pkg::BCD_ADJ;
			end
			dig_next[k] = d5[3:0];
		end
	end

	// Write sequencer. Each digit of the field gives up to three beats: an
	// optional minus sign one place to its left, the digit itself, and an
	// optional decimal point after it.
	assign cur_d = dig_q[idx_q];
	assign is_pt = pt_en_q && (sbdf_pkg::PPOS_W'(idx_q) == pt_q);
	assign sig   = (cur_d != 4'd0) || is_pt;

	// Any nonzero digit above the shown field means the value does not fit.
	always_comb begin
		ovf = 1'b0;
		for (int k = 0; k < sbdf_pkg::NUM_DIGITS; k++) begin
			if ((sbdf_pkg::IDX_W'(k) < first_q) && (dig_q[k] != 4'd0)) begin
				ovf = 1'b1;
			end
		end
	end

	assign need_sign = !ovf && minus_q && blank_q && sig;
	assign sign_wr   = (ph_q == sbdf_pkg::PH_SIGN) && need_sign;
	assign pt_wr     = (ph_q == sbdf_pkg::PH_POINT);
	assign load      = (state_q == sbdf_pkg::ST_EMIT) && (!o_valid_q || result.ready);

	always_comb begin
		w_end = 1'b0;
		if (sign_wr) begin
			w_pos  = n_q - sbdf_pkg::POS_W'(1);
			w_char = sbdf_pkg::CH_MINUS;
			w_last = 1'b0;
		end else if (pt_wr) begin
			w_pos  = n_q;
			w_char = sbdf_pkg::CH_POINT;
			w_last = (idx_q == LAST_IDX);
			w_end  = w_last;
		end else begin
			w_pos = n_q;
			if (ovf) begin
				w_char = sbdf_pkg::CH_MINUS;
			end else if (!blank_q || sig) begin
				w_char = sbdf_pkg::CH_ZERO + {2'b00, cur_d};
			end else begin
				w_char = sbdf_pkg::CH_SPACE;
			end
			w_last = (idx_q == LAST_IDX) && !is_pt;
			w_end  = w_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_res_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			hi_res_q <= cfg.hi_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sbdf_pkg::ST_IDLE;
			ph_q      <= sbdf_pkg::PH_SIGN;
			bit_cnt_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			case (state_q)
				sbdf_pkg::ST_IDLE: begin
					if (item_acc) begin
						state_q   <= sbdf_pkg::ST_CONV;
						ph_q      <= sbdf_pkg::PH_SIGN;
						bit_cnt_q <= '0;
					end
				end
				sbdf_pkg::ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + sbdf_pkg::BIT_CNT_W'(1);
					if (bit_cnt_q == LAST_BIT) begin
						state_q <= sbdf_pkg::ST_EMIT;
					end
				end
				sbdf_pkg::ST_EMIT: begin
					if (load) begin
						if (sign_wr) begin
							ph_q <= sbdf_pkg::PH_DIGIT;
						end else if (!pt_wr && is_pt) begin
							ph_q <= sbdf_pkg::PH_POINT;
						end else begin
							ph_q <= sbdf_pkg::PH_SIGN;
						end
						if (w_end) begin
							state_q <= sbdf_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= sbdf_pkg::ST_IDLE;
				end
			endcase

			if (load) begin
				o_valid_q <= 1'b1;
			end else if (result.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			minus_q <= raw[sbdf_pkg::MAG_W-1];
			mag_q   <= raw[sbdf_pkg::MAG_W-1] ? (sbdf_pkg::MAG_W'(0) - raw) : raw;
			first_q <= sbdf_pkg::IDX_W'(first_in);
			idx_q   <= sbdf_pkg::IDX_W'(first_in);
			n_q     <= sbdf_pkg::POS_W'(first_in) + sbdf_pkg::POS_W'(1);
			pt_en_q <= (item.point_pos != '0) && (item.point_pos <= SPOS_MAX);
			pt_q    <= item.point_pos - sbdf_pkg::PPOS_W'(1);
			blank_q <= 1'b1;
			for (int k = 0; k < sbdf_pkg::NUM_DIGITS; k++) begin
				dig_q[k] <= 4'd0;
			end
		end else if (state_q == sbdf_pkg::ST_CONV) begin
			mag_q <= {mag_q[sbdf_pkg::MAG_W-2:0], 1'b0};
			for (int k = 0; k < sbdf_pkg::NUM_DIGITS; k++) begin
				dig_q[k] <= dig_next[k];
			end
		end else if (load) begin
			if (!sign_wr) begin
				n_q <= n_q + sbdf_pkg::POS_W'(1);
			end
			if (!sign_wr && !pt_wr) begin
				blank_q <= blank_q && !sig;
			end
			if (pt_wr || (!sign_wr && !is_pt)) begin
				idx_q <= idx_q + sbdf_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			o_pos_q  <= w_pos;
			o_char_q <= w_char;
			o_last_q <= w_last;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> (state_q == sbdf_pkg::ST_CONV) && (bit_cnt_q == '0))
		else $error("accepted value did not start conversion");

	a_conv_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbdf_pkg::ST_CONV) && (bit_cnt_q == LAST_BIT)
		|=> (state_q == sbdf_pkg::ST_EMIT))
		else $error("conversion did not end after the last bit");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbdf_pkg::ST_EMIT) |-> (idx_q <= LAST_IDX) && (first_q <= idx_q))
		else $error("digit index left the shown field");

	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.last |=> !result.valid)
		else $error("character beat after the final beat of a value");
`endif

endmodule

[tb/sbdf_char_checker.sv]
// Checker for the signed BCD display formatter: watches the three channels,
// predicts the character beats of each accepted value and compares them.
// Depends on sbdf_pkg and the channel interfaces in sbdf_if.sv.
module sbdf_char_checker (
	input  logic    clk,
	input  logic    arst_n,
	sbdf_cfg_if     cfg,
	sbdf_item_if    item,
	sbdf_result_if  result,
	output int      errors,
	output int      pending,
	output int      checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MSG_LEN    = 16;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic [sbdf_pkg::POS_W-1:0]  position;
		logic [sbdf_pkg::CHAR_W-1:0] character;
		logic                        last;
	} char_beat_t;

	char_beat_t awaited_chars[$];
	logic       shadow_hi_res = 1'b0;
	int         mismatches = 0;
	int         beats_seen = 0;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t ns: mismatch: %s", $realtime, msg);
	endtask

	function automatic void add_char(input int pos,
			input logic [sbdf_pkg::CHAR_W-1:0] ch);
		char_beat_t beat;
		if (pos < 0 || pos >= MSG_LEN)
			return;
		beat.position  = sbdf_pkg::POS_W'(pos);
		beat.character = ch;
		beat.last      = 1'b0;
		awaited_chars.push_back(beat);
	endfunction

	// Works out the character beats of one value under the current hi_res.
	function automatic void forecast_writes(input logic [31:0] raw, input logic [3:0] sp_in,
			input logic [3:0] pp_in);
		logic            neg;
		logic [31:0]     mag;
		longint unsigned rest;
		int              dig [sbdf_pkg::NUM_DIGITS];
		int              sp, lo, pt, first, n, base;
		bit              overflow, started;
		neg  = raw[31];
		mag  = neg ? (32'd0 - raw) : raw;
		rest = mag;
		// Decimal digits by division; index 0 is the most significant.
		for (int k = sbdf_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
			dig[k] = int'(rest % 10);
			rest   = rest / 10;
		end
		lo = shadow_hi_res ? 2 : 1;
		sp = int'(sp_in);
		if (sp < lo)
			sp = lo;
		if (sp > sbdf_pkg::NUM_DIGITS)
			sp = sbdf_pkg::NUM_DIGITS;
		pt    = (pp_in >= 1 && pp_in <= sbdf_pkg::NUM_DIGITS) ? int'(pp_in) - 1 : -1;
		first = shadow_hi_res ? sp - 2 : sp - 1;
		n     = first + 1;
		base  = awaited_chars.size();
		overflow = 1'b0;
		for (int i = 0; i < first; i++)
			if (dig[i] != 0)
				overflow = 1'b1;
		started = 1'b0;
		for (int i = first; i < sbdf_pkg::NUM_DIGITS; i++) begin
			if (overflow) begin
				add_char(n, sbdf_pkg::CH_MINUS);
			end else begin
				if (!started && (dig[i] != 0 || i == pt)) begin
					if (neg)
						add_char(n - 1, sbdf_pkg::CH_MINUS);
					started = 1'b1;
				end
				add_char(n, started ?
					sbdf_pkg::CHAR_W'(int'(sbdf_pkg::CH_ZERO) + dig[i]) :
					sbdf_pkg::CH_SPACE);
			end
			n++;
			if (i == pt) begin
				add_char(n, sbdf_pkg::CH_POINT);
				n++;
			end
		end
		if (awaited_chars.size() > base)
			awaited_chars[awaited_chars.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n) begin
			// A value taken at the same edge as a register write still sees the
			// old hi_res, as the block does.
			if (item.valid && item.ready)
				forecast_writes(item.value, item.start_pos, item.point_pos);
			if (cfg.valid && cfg.ready)
				shadow_hi_res = cfg.hi_res;
			if (result.valid && result.ready) begin
				beats_seen++;
				if (awaited_chars.size() == 0) begin
					report($sformatf("beat at position %0d char 0x%0h with nothing awaited",
						result.position, result.character));
				end else begin
					want = awaited_chars.pop_front();
					if (result.position !== want.position)
						report($sformatf("beat %0d position %0d, wanted %0d",
							beats_seen, result.position, want.position));
					if (result.character !== want.character)
						report($sformatf("beat %0d char 0x%0h, wanted 0x%0h",
							beats_seen, result.character, want.character));
					if (result.last !== want.last)
						report($sformatf("beat %0d last %0b, wanted %0b",
							beats_seen, result.last, want.last));
				end
			end
		end
		errors  <= mismatches;
		pending <= awaited_chars.size();
		checked <= beats_seen;
	end

endmodule

[tb/tb.sv]
// Top of the testbench for the signed BCD display formatter: clock, reset,
// value and hi_res stimulus, output back-pressure and the verdict.
// Depends on sbdf_pkg, sbdf_if.sv, the block itself and sbdf_char_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Random part: four phases, hi_res alternating, no idling in the last one.
	localparam int     RANDOM_PHASES = 4;
	localparam int     PHASE_VALUES  = 90;
	// Settling wait, longer than one value's time in the block.
	localparam int     SETTLE_CYCLES = 48;
	// Long output hold-off, well beyond one value's time in the block.
	localparam int     HOLD_CYCLES   = 80;
	// Hard limit on the whole run, in ns.
	localparam longint LIMIT_NS      = 4_000_000;

	logic clk;
	logic arst_n;
	logic idling = 1'b1;
	int   hold_asked = 0;
	int   hold_served = 0;
	int   values_sent = 0;
	int   errors;
	int   pending;
	int   checked;

	// Corner values of the 32-bit field: zero, plus and minus one, both ends
	// of the signed range and both ends of the documented display range.
	logic [31:0] corner_values [7] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h7FFF_FFFF, 32'h7735_93FF, 32'h88CA_6C01};

	sbdf_cfg_if    cfg_ch();
	sbdf_item_if   item_ch();
	sbdf_result_if result_ch();

	signed_bcd_display_formatter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	sbdf_char_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.item    (item_ch),
		.result  (result_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops beats.
	initial begin
		#(LIMIT_NS);
		$display("FAIL signed_bcd_display_formatter");
		$finish;
	end

	// Receiver side. Normally ready, with short random stalls while idling is
	// on. When the stimulus asks for a hold-off, ready stays low for a long
	// stretch so that the block's output register fills and the input stalls.
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served++;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// Writes hi_res. Only called while nothing is in flight.
	task automatic set_hi_res(input logic hr);
		cfg_ch.valid  <= 1'b1;
		cfg_ch.hi_res <= hr;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Offers one value and returns at the edge where its beat is taken. Valid
	// stays high into the next call unless that call opens an idle burst, so
	// back-to-back values never toggle valid within one step.
	task automatic offer_value(input logic [31:0] v, input logic [3:0] sp,
			input logic [3:0] pp);
		if (idling && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.value     <= v;
		item_ch.start_pos <= sp;
		item_ch.point_pos <= pp;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		values_sent++;
	endtask

	// Random value. Most values are sized to fit the shown field so that the
	// digit, sign and point paths get most of the traffic; the rest are raw
	// 32-bit patterns, corners and tiny values, which often overflow into dashes.
	// Start and point positions now and then take the out-of-range codes.
	task automatic offer_random();
		int              sp, pp, lo, ndig;
		longint unsigned span;
		logic [31:0]     mag;
		sp = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
		pp = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 10);
		case ($urandom_range(0, 9))
			0: begin
				mag = $urandom();
			end
			1: begin
				mag = corner_values[$urandom_range(0, 6)];
			end
			2: begin
				mag = $urandom_range(0, 20);
			end
			default: begin
				lo   = (sp < 1) ? 1 :
					((sp > sbdf_pkg::NUM_DIGITS) ? sbdf_pkg::NUM_DIGITS : sp);
				ndig = $urandom_range(1, sbdf_pkg::NUM_DIGITS + 1 - lo);
				span = 1;
				repeat (ndig) span = span * 10;
				mag  = 32'(64'($urandom()) % span);
			end
		endcase
		offer_value($urandom_range(0, 1) ? (32'd0 - mag) : mag, 4'(sp), 4'(pp));
	endtask

	// Drops valid, waits until every awaited beat has arrived, then lets the
	// block's own latency pass so that it is idle for a register write.
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.hi_res     <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.value     <= '0;
		item_ch.start_pos <= '0;
		item_ch.point_pos <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed values with the sign position reserved (hi_res low).
		set_hi_res(1'b0);
		offer_value(32'd0, 4'd1, 4'd0);           // zero without a point: all blanks
		offer_value(32'd0, 4'd10, 4'd1);          // zero with the point on the top digit
		offer_value(32'h7735_93FF, 4'd1, 4'd0);   // largest documented value, full field
		offer_value(32'h88CA_6C01, 4'd1, 4'd5);   // smallest documented value with a point
		offer_value(32'h8000_0000, 4'd1, 4'd0);   // most negative, converted unsigned
		offer_value(32'h7FFF_FFFF, 4'd1, 4'd10);  // most positive, point on the last digit
		offer_value(-5, 4'd0, 4'd1);              // start below range saturates
		offer_value(123456, 4'd15, 4'd15);        // start above range, point out of range
		offer_value(-42, 4'd8, 4'd9);             // minus right before the first digit
		offer_value(12345, 4'd9, 4'd0);           // too wide for the field: dashes
		offer_value(-1234567, 4'd5, 4'd7);        // dashes with a point among them
		offer_value(-7, 4'd10, 4'd10);            // single digit field with sign and point
		offer_value(-3, 4'd4, 4'd8);              // minus lands before the point digit
		offer_value(32'hFFFF_FFFF, 4'd10, 4'd0);  // minus one
		settle();

		// Directed values with the extra digit (hi_res high).
		set_hi_res(1'b1);
		offer_value(32'd0, 4'd0, 4'd0);           // start below two saturates to two
		offer_value(-9, 4'd1, 4'd10);
		offer_value(32'h88CA_6C01, 4'd2, 4'd0);
		offer_value(987654321, 4'd2, 4'd3);
		offer_value(32'h8000_0000, 4'd15, 4'd15);
		offer_value(-100, 4'd10, 4'd9);           // overflow in the narrowest field
		offer_value(-250, 4'd8, 4'd9);
		settle();

		// Random phases. The second one starts with a long output hold-off,
		// and the last one runs with no idling on either side.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			idling <= (phase < RANDOM_PHASES - 1);
			set_hi_res(phase % 2 == 0);
			if (phase == 1)
				hold_asked <= hold_asked + 1;
			repeat (PHASE_VALUES) offer_random();
			settle();
		end

		$display("Run covered %0d values: corner cases, then random phases with hi_res low",
			values_sent);
		$display("and high, random stalls and one long output hold-off; %0d beats compared.",
			checked);
		if (errors == 0 && pending == 0)
			$display("PASS signed_bcd_display_formatter");
		else
			$display("FAIL signed_bcd_display_formatter");
		$finish;
	end

endmodule
